FILE: rtl/tfa_pkg.sv
package tfa_pkg;

  localparam int WINDOW_LEN = 5;
  localparam int NUM_CH     = 3;
  localparam int NUM_VLD    = 2;   // channels that keep per-entry valid bits
  localparam int RAW_W      = 16;
  localparam int Q_W        = 13;
  localparam int OUT_W      = 15;
  localparam int OPEN_BIT   = 2;
  localparam int Q_LSB      = 3;

  localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = Q_W + CNT_W;
  localparam int DVD_W  = SUM_W + 3;          // holds 5 * sum
  localparam int DVS_W  = CNT_W + 1;          // holds 2 * count
  localparam int STEP_W = $clog2(DVD_W);

  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(WINDOW_LEN - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DVD_W - 1);

  typedef struct packed {
    logic [RAW_W-1:0] raw_frame_ch1;
    logic [RAW_W-1:0] raw_frame_ch2;
    logic [RAW_W-1:0] raw_frame_ch3;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] temp_ch1_tenths;
    logic [OUT_W-1:0] temp_ch2_tenths;
    logic [OUT_W-1:0] temp_ch3_tenths;
    logic             fresh_ch1;
    logic             fresh_ch2;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_PREP,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sum_last;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

FILE: rtl/tfa_if.sv
interface tfa_in_if import tfa_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tfa_out_if import tfa_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/tfa_datapath.sv
module tfa_datapath import tfa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  cmd_t      cmd,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output status_t   status
);

  logic [RAW_W-1:0]      raw      [NUM_CH];
  logic [NUM_CH-1:0]     ok;
  logic [Q_W-1:0]        q_in     [NUM_CH];
  logic [Q_W-1:0]        wval     [NUM_CH];

  logic [Q_W-1:0]        win      [NUM_CH][WINDOW_LEN];
  logic [WINDOW_LEN-1:0] win_ok   [NUM_VLD];
  logic [POS_W-1:0]      pos;
  logic                  full;
  logic [Q_W-1:0]        last_good;

  logic [Q_W-1:0]        cur_q    [NUM_CH];
  logic [NUM_CH-1:0]     cur_ok;

  logic [POS_W-1:0]      idx;
  logic [NUM_CH-1:0]     ent_ok;
  logic [SUM_W-1:0]      acc      [NUM_CH];
  logic [CNT_W-1:0]      cnt      [NUM_CH];

  logic [SUM_W-1:0]      num_sel  [NUM_CH];
  logic [CNT_W-1:0]      den_sel  [NUM_CH];
  logic [DVD_W-1:0]      dvd      [NUM_CH];
  logic [DVS_W-1:0]      dvs      [NUM_CH];
  logic [DVS_W-1:0]      rem      [NUM_CH];
  logic [DVS_W:0]        trial    [NUM_CH];
  logic [DVS_W:0]        diff     [NUM_CH];
  logic [NUM_CH-1:0]     ge;
  logic [STEP_W-1:0]     step;
  logic [NUM_CH-1:0]     nz;

  logic [OUT_W-1:0]      held     [NUM_CH];
  logic [OUT_W-1:0]      held_next[NUM_CH];

  assign raw[0] = in_data.raw_frame_ch1;
  assign raw[1] = in_data.raw_frame_ch2;
  assign raw[2] = in_data.raw_frame_ch3;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      ok[c]   = !raw[c][OPEN_BIT];
      q_in[c] = raw[c][Q_LSB +: Q_W];
    end
    wval[0] = ok[0] ? q_in[0] : '0;
    wval[1] = ok[1] ? q_in[1] : '0;
    // open probe on channel 3 falls back to its last good reading
    wval[2] = ok[2] ? q_in[2] : last_good;
  end

  // window write and position
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      full      <= 1'b0;
      last_good <= '0;
      for (int c = 0; c < NUM_VLD; c++) begin
        win_ok[c] <= '0;
      end
    end else if (cmd.load) begin
      pos       <= (pos == LAST_POS) ? '0 : pos + 1'b1;
      full      <= full | (pos == LAST_POS);
      last_good <= wval[2];
      for (int c = 0; c < NUM_VLD; c++) begin
        win_ok[c][pos] <= ok[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < NUM_CH; c++) begin
        win[c][pos] <= wval[c];
        cur_q[c]    <= wval[c];
      end
      cur_ok <= {1'b1, ok[1:0]};
    end
  end

  // window sweep, one entry per cycle for all channels
  always_comb begin
    ent_ok[0] = win_ok[0][idx];
    ent_ok[1] = win_ok[1][idx];
    ent_ok[2] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        acc[c] <= '0;
        cnt[c] <= '0;
      end
    end else if (cmd.sum_step) begin
      idx <= (idx == LAST_POS) ? '0 : idx + 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        if (ent_ok[c]) begin
          acc[c] <= acc[c] + SUM_W'(win[c][idx]);
          cnt[c] <= cnt[c] + 1'b1;
        end
      end
    end
  end

  assign status.sum_last = (idx == LAST_POS);

  // until the window fills, a single sample is scaled on its own
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      num_sel[c] = full ? acc[c] : SUM_W'(cur_q[c]);
      den_sel[c] = full ? cnt[c] : CNT_W'(cur_ok[c]);
    end
  end

  // restoring divider per channel: 5*sum / (2*count), one quotient bit a cycle
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      trial[c] = {rem[c], dvd[c][DVD_W-1]};
      diff[c]  = trial[c] - {1'b0, dvs[c]};
      ge[c]    = (trial[c] >= {1'b0, dvs[c]});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      step <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        dvd[c] <= (DVD_W'(num_sel[c]) << 2) + DVD_W'(num_sel[c]);
        dvs[c] <= {den_sel[c], 1'b0};
        rem[c] <= '0;
        nz[c]  <= (den_sel[c] != '0);
      end
    end else if (cmd.div_step) begin
      step <= step + 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        rem[c] <= ge[c] ? diff[c][DVS_W-1:0] : trial[c][DVS_W-1:0];
        dvd[c] <= {dvd[c][DVD_W-2:0], ge[c]};
      end
    end
  end

  assign status.div_last = (step == LAST_STEP);

  // output register; a channel with nothing valid keeps its old figure
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      held_next[c] = nz[c] ? dvd[c][OUT_W-1:0] : held[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CH; c++) begin
        held[c] <= '0;
      end
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
      for (int c = 0; c < NUM_CH; c++) begin
        held[c] <= held_next[c];
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.temp_ch1_tenths <= held_next[0];
      out_data.temp_ch2_tenths <= held_next[1];
      out_data.temp_ch3_tenths <= held_next[2];
      out_data.fresh_ch1       <= nz[0];
      out_data.fresh_ch2       <= nz[1];
    end
  end

  assign status.out_busy = out_valid & ~out_ready;

endmodule

FILE: rtl/tfa_controller.sv
module tfa_controller import tfa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  status_t status,
  output logic    in_ready,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SUM;
      end
      S_SUM: begin
        if (status.sum_last) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
      end
      S_PREP: begin
        cmd.div_init = 1'b1;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_DONE: begin
        // hold the finished result until the output register frees up
        cmd.out_load = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/thermocouple_frame_averager_core.sv
// A result is loaded into the output register after the input transfer, the window sweep,
// the divider set-up and the bit-serial divider, one quotient bit per cycle for all three
// channels. One item is in work at a time: a new input is taken only after its result is
// loaded, and loading waits while an earlier result is stalled.
// Reset (rst, synchronous): window valid bits, position, fill flag, last good value,
// held outputs and the controller are cleared; window data is not.
module thermocouple_frame_averager_core import tfa_pkg::*; (
  input logic      clk,
  input logic      rst,
  tfa_in_if.sink   sample,
  tfa_out_if.source result
);

  cmd_t      cmd;
  status_t   status;
  logic      out_valid;
  out_item_t out_data;
  logic      in_ready;

  tfa_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample.valid),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  tfa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (sample.data),
    .cmd       (cmd),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

  assign sample.ready = in_ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.sum_step, cmd.div_init, cmd.div_step, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result.valid && !result.ready))
    else $error("pending result overwritten");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> !sample.ready)
    else $error("second item taken while one is in work");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> result.valid)
    else $error("loaded result not presented");

endmodule
